@@ src/cvza_pkg.sv @@
// Shared types and constants of the 3x3 zero-padded averaging convolution.
`default_nettype none

package cvza_pkg;

  localparam int DEF_MAX_IMAGE_WIDTH  = 1024;
  localparam int DEF_MAX_IMAGE_HEIGHT = 1024;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int VALUE_W    = 24;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int SUM_W      = PROD_W + 3;
  localparam int MAG_W      = SUM_W - 1;

  // floor(n / 9) == (n * DIV9_RECIP) >> DIV9_SHIFT for n < 2**27
  localparam int              DIV9_SHIFT = 30;
  localparam logic [MAG_W-1:0] DIV9_RECIP = 27'd119304648;

  localparam int OUT_DEPTH = 16;

  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_MASK_ROW_TOP    = 3'd2,
    REG_MASK_ROW_MIDDLE = 3'd3,
    REG_MASK_ROW_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
    logic a_last;
    logic b_eof;
  } res_flags_t;

  typedef struct packed {
    res_flags_t         flags;
    logic [VALUE_W-1:0] a_val;
    logic [VALUE_W-1:0] b_val;
  } res_slot_t;

endpackage

`default_nettype wire

@@ src/cvza_mac.sv @@
// Multiply-accumulate and divide-by-nine pipeline for one 3x3 window.
`default_nettype none

module cvza_mac
  import cvza_pkg::*;
(
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  res_flags_t                         in_flags,
  input  logic [2:0][2:0][PIX_W-1:0]         win,
  input  logic [2:0][CFG_DATA_W-1:0]         mask,
  output logic                               out_valid,
  output res_slot_t                          out_slot
);

  localparam int STAGES = 5;

  logic [STAGES-1:0]        vld;
  res_flags_t               flg [STAGES];

  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [SUM_W-1:0]  sum_lr;
  logic signed [SUM_W-1:0]  sum_rc;
  logic signed [SUM_W-1:0]  acc_lr;
  logic signed [SUM_W-1:0]  acc_rc;
  logic signed [SUM_W-1:0]  full_a;
  logic signed [SUM_W-1:0]  full_b;
  logic [MAG_W-1:0]         mag_a;
  logic [MAG_W-1:0]         mag_b;
  logic [1:0]               neg_m;
  logic [1:0]               neg_q;
  logic [2*MAG_W-1:0]       qp_a;
  logic [2*MAG_W-1:0]       qp_b;
  logic [VALUE_W-1:0]       quo_a;
  logic [VALUE_W-1:0]       quo_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    flg[0] <= in_flags;
    for (int i = 1; i < STAGES; i++) begin
      flg[i] <= flg[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] <= PROD_W'($signed({1'b0, win[r][c]}) *
                              $signed(mask[r][COEF_W*c +: COEF_W]));
      end
    end
  end

  always_comb begin
    acc_lr = '0;
    acc_rc = '0;
    for (int r = 0; r < 3; r++) begin
      acc_lr = acc_lr + SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]);
      acc_rc = acc_rc + SUM_W'(prod[r][2]);
    end
  end

  always_ff @(posedge clk) begin
    sum_lr <= acc_lr;
    sum_rc <= acc_rc;
    full_a <= sum_lr + sum_rc;
    full_b <= sum_lr;
    neg_m  <= {full_b[SUM_W-1], full_a[SUM_W-1]};
    mag_a  <= MAG_W'(full_a[SUM_W-1] ? -full_a : full_a);
    mag_b  <= MAG_W'(full_b[SUM_W-1] ? -full_b : full_b);
  end

  assign qp_a = mag_a * DIV9_RECIP;
  assign qp_b = mag_b * DIV9_RECIP;

  always_ff @(posedge clk) begin
    quo_a <= qp_a[DIV9_SHIFT +: VALUE_W];
    quo_b <= qp_b[DIV9_SHIFT +: VALUE_W];
    neg_q <= neg_m;
  end

  assign out_valid      = vld[STAGES-1];
  assign out_slot.flags = flg[STAGES-1];
  assign out_slot.a_val = neg_q[0] ? -quo_a : quo_a;
  assign out_slot.b_val = neg_q[1] ? -quo_b : quo_b;

endmodule

`default_nettype wire

@@ src/cvza_outq.sv @@
// Output queue of result slots, each slot holding up to two results.
`default_nettype none

module cvza_outq
  import cvza_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  res_slot_t          slot,
  output logic               slot_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VALUE_W-1:0] m_tdata,   // value[23:0]
  output logic               m_tuser,   // last_in_item
  output logic               m_tlast
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  res_slot_t        slots [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             half;
  res_slot_t        head;
  logic             show_a;
  logic             xfer;

  assign head     = slots[rd_ptr];
  assign show_a   = head.flags.a_valid && !half;
  assign m_tvalid = (count != '0);
  assign m_tdata  = show_a ? head.a_val : head.b_val;
  assign m_tuser  = show_a ? head.flags.a_last : 1'b1;
  assign m_tlast  = show_a ? 1'b0 : head.flags.b_eof;
  assign xfer     = m_tvalid && m_tready;
  assign slot_pop = xfer && !(show_a && head.flags.b_valid);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      half   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (slot_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(slot_pop);
      if (slot_pop) begin
        half <= 1'b0;
      end else if (xfer) begin
        half <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/conv3x3_zero_pad_average.sv @@
// Top level of the streaming 3x3 zero-padded convolution with divide by nine.
//
// Pixels enter on the s_ channel in raster order, s_tdata the pixel and s_tuser
// the command (set for a flush item of the zero bottom row). Results leave on
// the m_ channel: m_tdata the signed 24-bit value, m_tuser set on the final
// result of an input item, m_tlast on the bottom right pixel of the frame.
// Registers must be written through cfg_we/cfg_index/cfg_data only while idle;
// the block itself does not enforce this. One item is accepted per cycle
// while s_tready is high; each item does one read and one write of the single
// line memory, which sets that rate. A result passes the stage-one registers,
// the window register, the MAC pipeline and the result queue; the last pixel
// of a row gives two results on consecutive output transactions. After reset
// the line memory is cleared one entry per cycle, with s_tready low until
// every entry is cleared; configuration writes are taken. A result queue of 16
// item slots parts the two sides; when the receiver stalls, s_tready drops once
// queued and in-flight items fill those slots, and nothing is lost.
`default_nettype none

module conv3x3_zero_pad_average
  import cvza_pkg::*;
#(
  parameter int MAX_IMAGE_WIDTH  = DEF_MAX_IMAGE_WIDTH,
  parameter int MAX_IMAGE_HEIGHT = DEF_MAX_IMAGE_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // pixel[7:0]
  input  logic                  s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VALUE_W-1:0]    m_tdata,   // value[23:0]
  output logic                  m_tuser,   // last_in_item
  output logic                  m_tlast,   // end_of_frame
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W  = $clog2(MAX_IMAGE_WIDTH);
  localparam int WCMP_W = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_IMAGE_HEIGHT + 1);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int LINE_W = 2 * PIX_W;

  logic [DIM_W-1:0]          image_width;
  logic [DIM_W-1:0]          image_height;
  logic [CFG_DATA_W-1:0]     mask_row_top;
  logic [CFG_DATA_W-1:0]     mask_row_middle;
  logic [CFG_DATA_W-1:0]     mask_row_bottom;

  logic [WCMP_W-1:0]         w_eff;
  logic [ROW_W-1:0]          h_eff;

  logic [COL_W-1:0]          col_pos;
  logic [ROW_W-1:0]          row_pos;
  logic                      acc;
  logic                      pad_row;
  logic                      last_col;
  logic [PIX_W-1:0]          pix_v;

  logic                      clr_active;
  logic [COL_W-1:0]          clr_addr;
  logic [CNT_W-1:0]          used;

  logic [LINE_W-1:0]         line_mem [MAX_IMAGE_WIDTH];
  logic [LINE_W-1:0]         rdata;
  logic                      mem_we;
  logic [COL_W-1:0]          mem_wa;
  logic [LINE_W-1:0]         mem_wd;

  logic                      s1_valid;
  logic [COL_W-1:0]          s1_x;
  logic [PIX_W-1:0]          s1_v;
  logic                      s1_first;
  logic                      s1_top_ok;
  logic                      s1_mid_ok;
  logic                      s1_fwd;
  res_flags_t                s1_flags;
  logic [LINE_W-1:0]         fwd_data;
  logic [LINE_W-1:0]         pair;
  logic [PIX_W-1:0]          top_pix;
  logic [PIX_W-1:0]          mid_pix;

  logic [2:0][2:0][PIX_W-1:0] win;
  logic [2:0][2:0][PIX_W-1:0] win_next;
  logic                       s2_valid;
  res_flags_t                 s2_flags;

  logic                      mac_valid;
  res_slot_t                 mac_slot;
  logic                      push;
  logic                      drop;
  logic                      slot_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= DIM_W'(1024);
      image_height    <= DIM_W'(1024);
      mask_row_top    <= '0;
      mask_row_middle <= '0;
      mask_row_bottom <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[DIM_W-1:0];
        REG_MASK_ROW_TOP:    mask_row_top    <= cfg_data;
        REG_MASK_ROW_MIDDLE: mask_row_middle <= cfg_data;
        REG_MASK_ROW_BOTTOM: mask_row_bottom <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (image_width < DIM_W'(2)) begin
      w_eff = WCMP_W'(2);
    end else if (32'(image_width) > MAX_IMAGE_WIDTH) begin
      w_eff = WCMP_W'(MAX_IMAGE_WIDTH);
    end else begin
      w_eff = WCMP_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(image_height) > MAX_IMAGE_HEIGHT) begin
      h_eff = ROW_W'(MAX_IMAGE_HEIGHT);
    end else begin
      h_eff = ROW_W'(image_height);
    end
  end

  assign s_tready = !clr_active && (used < CNT_W'(OUT_DEPTH));
  assign acc      = s_tvalid && s_tready;
  assign pad_row  = (row_pos >= h_eff);
  assign last_col = (WCMP_W'(col_pos) + WCMP_W'(1) >= w_eff);
  assign pix_v    = (pad_row || s_tuser == CMD_FLUSH) ? '0 : s_tdata;

  // position counters, clearing pass and slot credit
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos    <= '0;
      row_pos    <= '0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      used       <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      if (acc) begin
        if (last_col) begin
          col_pos <= '0;
          row_pos <= pad_row ? '0 : row_pos + ROW_W'(1);
        end else begin
          col_pos <= col_pos + COL_W'(1);
        end
      end
      if (clr_active) begin
        clr_addr <= clr_addr + COL_W'(1);
        if (clr_addr == COL_W'(MAX_IMAGE_WIDTH - 1)) begin
          clr_active <= 1'b0;
        end
      end
      used     <= used + CNT_W'(acc) - CNT_W'(slot_pop) - CNT_W'(drop);
      s1_valid <= acc;
      s2_valid <= s1_valid;
    end
  end

  // line memory: {row two above, row one above} per column
  assign pair    = s1_fwd ? fwd_data : rdata;
  assign top_pix = s1_top_ok ? pair[LINE_W-1:PIX_W] : '0;
  assign mid_pix = s1_mid_ok ? pair[PIX_W-1:0] : '0;
  assign mem_we  = clr_active || s1_valid;
  assign mem_wa  = clr_active ? clr_addr : s1_x;
  assign mem_wd  = clr_active ? '0 : {pair[PIX_W-1:0], s1_v};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_wa] <= mem_wd;
    end
    if (acc) begin
      rdata <= line_mem[col_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x              <= col_pos;
      s1_v              <= pix_v;
      s1_first          <= (col_pos == '0);
      s1_top_ok         <= (row_pos >= ROW_W'(2));
      s1_mid_ok         <= (row_pos != '0);
      s1_fwd            <= s1_valid && (s1_x == col_pos);
      s1_flags.a_valid  <= (row_pos != '0) && (col_pos != '0);
      s1_flags.b_valid  <= (row_pos != '0) && last_col;
      s1_flags.a_last   <= !last_col;
      s1_flags.b_eof    <= pad_row;
    end
    if (s1_valid) begin
      fwd_data <= {pair[PIX_W-1:0], s1_v};
      win      <= win_next;
      s2_flags <= s1_flags;
    end
  end

  // shift window, clear at row start
  always_comb begin
    win_next = s1_first ? '0 : win;
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win_next[r][1];
      win_next[r][1] = win_next[r][2];
    end
    win_next[0][2] = top_pix;
    win_next[1][2] = mid_pix;
    win_next[2][2] = s1_v;
  end

  cvza_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_flags  (s2_flags),
    .win       (win),
    .mask      ({mask_row_bottom, mask_row_middle, mask_row_top}),
    .out_valid (mac_valid),
    .out_slot  (mac_slot)
  );

  assign push = mac_valid && (mac_slot.flags.a_valid || mac_slot.flags.b_valid);
  assign drop = mac_valid && !(mac_slot.flags.a_valid || mac_slot.flags.b_valid);

  cvza_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .slot     (mac_slot),
    .slot_pop (slot_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
